/* sv/fqq_pkg.sv */
// Package with shared types, codes and constants for the queue with queries.
package fqq_pkg;
	localparam int QueueDepthDefault = 32;

	typedef enum logic [2:0] {
		ACT_PUSH = 3'd0,
		ACT_POP = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_LIST = 3'd3,
		ACT_AVG = 3'd4,
		ACT_EVEN = 3'd5,
		ACT_COUNT = 3'd6,
		ACT_REV = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	typedef struct packed {
		action_t action;
		logic signed [31:0] operand_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		status_t status;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic [38:0] dividend;
		logic [6:0] divisor;
	} div_ctl_t;
endpackage

/* sv/fqq_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
module fqq_div import fqq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_ctl_t ctl,
	output logic done,
	output logic signed [31:0] quotient
);
	localparam int DW = 39;
	logic [DW-1:0] quo_q;
	logic [7:0] rem_q;
	logic [6:0] den_q;
	logic neg_q;
	logic busy_q;
	logic [5:0] cnt_q;
	logic [7:0] trial;
	logic [DW-1:0] qneg;

	assign trial = {rem_q[6:0], quo_q[DW-1]};
	assign qneg = neg_q ? (~quo_q + DW'(1)) : quo_q;
	assign quotient = qneg[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DW);
				neg_q <= ctl.dividend[DW-1];
				quo_q <= ctl.dividend[DW-1] ? (~ctl.dividend + DW'(1)) : ctl.dividend;
				den_q <= ctl.divisor;
				rem_q <= '0;
			end else if (busy_q) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

/* sv/fqq_store.sv */
// Entry memory with one write port and one registered read port.
module fqq_store import fqq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDefault,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [31:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/fifo_queue_with_queries_top.sv */
// Top level of the FIFO queue with list, average and match queries.
//  channel  | handshake            | payload
//  request  | start in, busy out   | req  (req_t)
//  result   | strobe out           | rsp  (rsp_t)
// Push and clear answer in the cycle after the request and never raise busy.
// Pop on a non-empty queue holds busy through the pop and drain states, then answers.
// A walk over n entries reads one entry per cycle, then holds busy in the drain state
// for the last read (the even list also in the flush state); reverse walks the read port backwards.
// Average holds busy through the walk, the divider start and the 39-step divider.
// Reset empties the queue at once; no clearing pass. Results cannot be stalled.
module fifo_queue_with_queries_top import fqq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	output logic busy,
	output logic strobe,
	output rsp_t rsp
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_DIV, S_POP, S_FLUSH} state_t;
	state_t state_q;
	action_t act_q;
	logic [31:0] opnd_q;
	logic [AW-1:0] rp_q, wp_q, addr_q;
	logic [CW-1:0] cnt_q, left_q;
	logic valid_s1, last_s1;
	logic [38:0] sum_q;
	logic [CW-1:0] hits_q;
	logic found_q;
	logic [31:0] held_q;
	logic we;
	logic [31:0] rdata;
	div_ctl_t dctl;
	logic ddone;
	logic signed [31:0] dquo;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : p + AW'(1);
	endfunction
	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
	endfunction

	assign we = start && !busy && req.action == ACT_PUSH && 32'(cnt_q) < QUEUE_DEPTH;
	assign busy = state_q != S_IDLE;

	fqq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(wp_q), .wdata(req.operand_value),
		.raddr(addr_q), .rdata(rdata)
	);

	fqq_div u_div (.clk(clk), .arst_n(arst_n), .ctl(dctl), .done(ddone), .quotient(dquo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rp_q <= '0;
			wp_q <= '0;
			cnt_q <= '0;
			strobe <= 1'b0;
			valid_s1 <= 1'b0;
			dctl.start <= 1'b0;
		end else begin
			strobe <= 1'b0;
			dctl.start <= 1'b0;
			valid_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= req.action;
						opnd_q <= req.operand_value;
						rsp.result_value <= '0;
						rsp.last <= 1'b1;
						sum_q <= '0;
						hits_q <= '0;
						found_q <= 1'b0;
						if (req.action == ACT_PUSH) begin
							strobe <= 1'b1;
							if (we) begin
								wp_q <= wrap_inc(wp_q);
								cnt_q <= cnt_q + CW'(1);
								rsp.status <= ST_OK;
							end else begin
								rsp.status <= ST_FULL;
							end
						end else if (req.action == ACT_CLEAR) begin
							strobe <= 1'b1;
							rsp.status <= ST_OK;
							rp_q <= '0;
							wp_q <= '0;
							cnt_q <= '0;
						end else if (cnt_q == '0) begin
							strobe <= 1'b1;
							rsp.status <= ST_EMPTY;
						end else if (req.action == ACT_POP) begin
							addr_q <= rp_q;
							state_q <= S_POP;
						end else begin
							addr_q <= (req.action == ACT_REV) ? wrap_dec(wp_q) : rp_q;
							left_q <= cnt_q;
							state_q <= S_WALK;
						end
					end
				end
				S_POP: begin
					state_q <= S_DRAIN;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						rp_q <= '0;
						wp_q <= '0;
					end else begin
						rp_q <= wrap_inc(rp_q);
					end
				end
				S_WALK: begin
					valid_s1 <= 1'b1;
					last_s1 <= left_q == CW'(1);
					addr_q <= (act_q == ACT_REV) ? wrap_dec(addr_q) : wrap_inc(addr_q);
					left_q <= left_q - CW'(1);
					if (left_q == CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (act_q == ACT_POP) begin
						strobe <= 1'b1;
						rsp.result_value <= rdata;
						rsp.status <= ST_OK;
						rsp.last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (ddone) begin
						strobe <= 1'b1;
						rsp.result_value <= dquo;
						rsp.status <= ST_OK;
						rsp.last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					strobe <= 1'b1;
					rsp.result_value <= found_q ? held_q : '0;
					rsp.status <= found_q ? ST_OK : ST_NOMATCH;
					rsp.last <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (valid_s1) begin
				case (act_q)
					ACT_LIST, ACT_REV: begin
						strobe <= 1'b1;
						rsp.result_value <= rdata;
						rsp.status <= ST_OK;
						rsp.last <= last_s1;
					end
					ACT_EVEN: begin
						if (!rdata[0]) begin
							found_q <= 1'b1;
							held_q <= rdata;
							if (found_q) begin
								strobe <= 1'b1;
								rsp.result_value <= held_q;
								rsp.status <= ST_OK;
								rsp.last <= 1'b0;
							end
						end
					end
					ACT_COUNT: begin
						if (last_s1) begin
							strobe <= 1'b1;
							rsp.result_value <= 32'(hits_q + CW'(rdata == opnd_q));
							rsp.status <= (hits_q == '0 && rdata != opnd_q) ? ST_NOMATCH : ST_OK;
							rsp.last <= 1'b1;
						end else begin
							hits_q <= hits_q + CW'(rdata == opnd_q);
						end
					end
					ACT_AVG: begin
						if (last_s1) begin
							dctl.start <= 1'b1;
							dctl.dividend <= sum_q + {{7{rdata[31]}}, rdata};
							dctl.divisor <= 7'(cnt_q);
						end else begin
							sum_q <= sum_q + {{7{rdata[31]}}, rdata};
						end
					end
					default: ;
				endcase
				if (last_s1) begin
					state_q <= (act_q == ACT_AVG) ? S_DIV :
						(act_q == ACT_EVEN) ? S_FLUSH : S_IDLE;
				end
			end
		end
	end

	// The even list holds back each even entry until the next one is seen, so the
	// final even entry goes out from the flush state with last set.

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= QUEUE_DEPTH) else $error("entry count exceeds depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> rp_q == '0 && wp_q == '0) else $error("pointers not reset on empty");
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.last |-> !busy)
		else $error("last result left block busy");
endmodule

/* dv/tb.sv */
// Self-checking testbench for the FIFO queue with list, average and match queries.
`timescale 1ns / 100ps

module tb;
	import fqq_pkg::*;

	localparam int Depth = QueueDepthDefault;
	localparam int CycleLimit = 400000;

	class queue_scoreboard;
		logic signed [31:0] entries[$];
		rsp_t pending[$];
		int errors;

		function void put(logic signed [31:0] v, status_t s);
			rsp_t r;
			r.result_value = v;
			r.status = s;
			r.last = 1'b0;
			pending.push_back(r);
		endfunction

		function void note_request(req_t q);
			int n;
			int hits;
			longint sum;
			n = pending.size();
			if (q.action == ACT_PUSH) begin
				if (entries.size() >= Depth) begin
					put(0, ST_FULL);
				end else begin
					entries.push_back(q.operand_value);
					put(0, ST_OK);
				end
			end else if (q.action == ACT_CLEAR) begin
				entries.delete();
				put(0, ST_OK);
			end else if (entries.size() == 0) begin
				put(0, ST_EMPTY);
			end else begin
				case (q.action)
					ACT_POP: begin
						put(entries.pop_front(), ST_OK);
					end
					ACT_LIST: begin
						foreach (entries[k]) put(entries[k], ST_OK);
					end
					ACT_AVG: begin
						sum = 0;
						foreach (entries[k]) sum += longint'(entries[k]);
						sum = sum / longint'(entries.size());
						put(sum[31:0], ST_OK);
					end
					ACT_EVEN: begin
						foreach (entries[k])
							if (!entries[k][0]) put(entries[k], ST_OK);
						if (pending.size() == n) put(0, ST_NOMATCH);
					end
					ACT_COUNT: begin
						hits = 0;
						foreach (entries[k])
							if (entries[k] == q.operand_value) hits++;
						put(hits, hits == 0 ? ST_NOMATCH : ST_OK);
					end
					default: begin
						for (int k = entries.size() - 1; k >= 0; k--) put(entries[k], ST_OK);
					end
				endcase
			end
			pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void report_mismatch(string field, longint got, longint want);
			$display("mismatch on %s: got %0d, expected %0d", field, got, want);
			errors++;
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", got.result_value, 0);
				return;
			end
			want = pending.pop_front();
			if (got.result_value !== want.result_value)
				report_mismatch("result_value", got.result_value, want.result_value);
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic strobe;
	rsp_t rsp;
	int cycles = 0;
	bit quiet = 1'b0;
	queue_scoreboard board = new();
	logic signed [31:0] recent[$];

	fifo_queue_with_queries_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .strobe(strobe), .rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && strobe) board.check_result(rsp);
		if (cycles > CycleLimit) begin
			$display("timeout");
			$display("** fifo_queue_with_queries_top: FAILED **");
			$finish;
		end
	end

	task automatic send_request(action_t a, logic signed [31:0] v);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req.action <= a;
		req.operand_value <= v;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_request(req);
		if (a == ACT_PUSH) recent.push_back(v);
		if (recent.size() > 8) void'(recent.pop_front());
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 7) - 3;
			3: return (recent.size() > 0) ? recent[$urandom_range(0, recent.size() - 1)] : 0;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int fill;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int a = 1; a < 8; a++) if (a != ACT_PUSH) send_request(action_t'(a), 0);
		send_request(ACT_PUSH, 32'sh7fffffff);
		send_request(ACT_PUSH, 32'sh80000000);
		send_request(ACT_PUSH, -3);
		send_request(ACT_PUSH, 4);
		for (int a = 3; a < 8; a++) send_request(action_t'(a), -3);
		send_request(ACT_COUNT, 5);
		send_request(ACT_POP, 0);
		send_request(ACT_POP, 0);
		send_request(ACT_POP, 0);
		send_request(ACT_EVEN, 0);
		send_request(ACT_POP, 0);
		send_request(ACT_CLEAR, 0);
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 10) quiet = 1'b1;
			fill = (phase % 3 == 0) ? Depth + 2 : $urandom_range(0, 12);
			for (int i = 0; i < fill; i++) send_request(ACT_PUSH, pick_value());
			for (int i = 0; i < 21; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: send_request(ACT_PUSH, pick_value());
					3, 4: send_request(ACT_POP, 0);
					5: send_request(($urandom_range(0, 7) == 0) ? ACT_CLEAR : ACT_LIST, 0);
					6: send_request(ACT_AVG, 0);
					7: send_request(ACT_EVEN, 0);
					8: send_request(ACT_COUNT, pick_value());
					default: send_request(ACT_REV, 0);
				endcase
			end
		end
		start <= 1'b0;
		while (board.pending.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("** fifo_queue_with_queries_top: PASSED **");
		end else begin
			$display("** fifo_queue_with_queries_top: FAILED **");
		end
		$finish;
	end
endmodule

/* fifo_queue_with_queries_top.f */
sv/fqq_pkg.sv
sv/fqq_div.sv
sv/fqq_store.sv
sv/fifo_queue_with_queries_top.sv
dv/tb.sv
